// ----- rtl/swp_pkg.sv -----
// Package for the sliding-window percentile unit: window size, sorted
// positions, time word type, cell control and sequencer state types.
// No dependencies.
package swp_pkg;

   localparam int SAMPLE_COUNT = 120;
   localparam int TIME_W       = 16;

   // Sorted positions read for a report (floor(N*p/100)).
   localparam int MEDIAN_POS = SAMPLE_COUNT * 50 / 100;
   localparam int P95_POS    = SAMPLE_COUNT * 95 / 100;
   localparam int P99_POS    = SAMPLE_COUNT * 99 / 100;
   localparam int MAX_POS    = SAMPLE_COUNT - 1;

   typedef logic [TIME_W-1:0] time_type;

   localparam time_type TIME_ZERO = '0;
   localparam time_type TIME_TOP  = '1;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_DELETE,
      OP_INSERT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      time_type    key;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DELETE,
      ST_INSERT,
      ST_REPORT
   } seq_state_type;

endpackage

// ----- rtl/swp_stream_if.sv -----
// Handshake channels of the sliding-window percentile unit: request words
// in, report words out. Depends on swp_pkg.
interface swp_req_if;
   import swp_pkg::*;
   logic     valid;
   logic     ready;
   logic     kind;
   time_type sample_time;
   modport source (output valid, output kind, output sample_time, input ready);
   modport sink   (input valid, input kind, input sample_time, output ready);
endinterface

interface swp_rsp_if;
   import swp_pkg::*;
   logic     valid;
   logic     ready;
   time_type median_time;
   time_type p95_time;
   time_type p99_time;
   time_type max_time;
   modport source (output valid, output median_time, output p95_time,
                   output p99_time, output max_time, input ready);
   modport sink   (input valid, input median_time, input p95_time,
                   input p99_time, input max_time, output ready);
endinterface

// ----- rtl/swp_cell.sv -----
// One cell of the window chain: an age slot (arrival order shift line)
// and a sorted slot (ordered list). Depends on swp_pkg.
module swp_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  swp_pkg::cell_ctrl_type ctrl,
   input  swp_pkg::time_type     age_left,
   input  swp_pkg::time_type     sort_left,
   input  swp_pkg::time_type     sort_right,
   output swp_pkg::time_type     age_q,
   output swp_pkg::time_type     sort_q
);
   import swp_pkg::*;

   time_type age_ff, age_in;
   time_type sort_ff, sort_in;

   always_comb begin
      age_in  = age_ff;
      sort_in = sort_ff;
      case (ctrl.op)
         OP_DELETE: begin
            // cells at or past the first copy of key pull from the right
            if (sort_ff >= ctrl.key) begin
               sort_in = sort_right;
            end
         end
         OP_INSERT: begin
            age_in = age_left;
            if (sort_ff >= ctrl.key) begin
               sort_in = (sort_left < ctrl.key) ? ctrl.key : sort_left;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff  <= TIME_ZERO;
         sort_ff <= TIME_ZERO;
      end else begin
         age_ff  <= age_in;
         sort_ff <= sort_in;
      end
   end

   assign age_q  = age_ff;
   assign sort_q = sort_ff;

endmodule

// ----- rtl/sliding_window_percentiles.sv -----
// Top level of the sliding-window percentile unit: sequencer, chain of
// window cells and report register. Depends on swp_pkg, swp_stream_if, swp_cell.
//
//  channel   dir  word fields                                   accepted when
//  req_chan  in   kind, sample_time                             valid & ready
//  rsp_chan  out  median_time, p95_time, p99_time, max_time     valid & ready
//
// Sequence: a sample word is accepted, then the oldest value is deleted, then
//   the new one is inserted; a report word is accepted, then waits for the output
//   register. Both sequences come from the sequencer driving the cell chain.
// Reset: synchronous; every cell clears to zero, so unwritten window
//   slots count as zero-time samples.
// Stalls: a pending result holds in the output register; samples are still
//   taken meanwhile; a second report blocks new words until the register frees.
module sliding_window_percentiles (
   input  logic      clock,
   input  logic      reset,
   swp_req_if.sink   req_chan,
   swp_rsp_if.source rsp_chan
);
   import swp_pkg::*;

   // Two views of the same window live in the chain:
   //   age slots  - last SAMPLE_COUNT samples in arrival order, oldest at the
   //                far end; this replaces the ring and its write position.
   //   sort slots - the same multiset kept in ascending order.
   // A new sample first deletes the oldest value from the sorted list (cells
   // at/after it shift down, the end cell takes TIME_TOP as filler), then
   // inserts the new value (cells at/after its place shift up) while the age
   // line shifts by one.

   seq_state_type state_ff, state_in;
   time_type      key_ff, key_in;
   logic          rsp_valid_ff, rsp_valid_in;
   time_type      median_ff, median_in;
   time_type      p95_ff, p95_in;
   time_type      p99_ff, p99_in;
   time_type      max_ff, max_in;
   cell_ctrl_type ctrl;

   time_type age_q  [SAMPLE_COUNT];
   time_type sort_q [SAMPLE_COUNT];

   logic req_take;
   logic rsp_free;

   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff;
      median_in    = median_ff;
      p95_in       = p95_ff;
      p99_in       = p99_ff;
      max_in       = max_ff;
      ctrl.op      = OP_HOLD;
      ctrl.key     = key_ff;
      req_chan.ready = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               key_in   = req_chan.sample_time;
               state_in = (req_chan.kind == KIND_REPORT) ? ST_REPORT : ST_DELETE;
            end
         end
         ST_DELETE: begin
            // oldest sample sits in the last age slot
            ctrl.op  = OP_DELETE;
            ctrl.key = age_q[MAX_POS];
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            ctrl.op  = OP_INSERT;
            ctrl.key = key_ff;
            state_in = ST_IDLE;
         end
         ST_REPORT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               median_in    = sort_q[MEDIAN_POS];
               p95_in       = sort_q[P95_POS];
               p99_in       = sort_q[P99_POS];
               max_in       = sort_q[MAX_POS];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      median_ff <= median_in;
      p95_ff    <= p95_in;
      p99_ff    <= p99_in;
      max_ff    <= max_in;
   end

   // cell chain; ends are tied so the shift rules need no special cells
   genvar gi;
   generate
      for (gi = 0; gi < SAMPLE_COUNT; gi++) begin : g_cell
         time_type age_left, sort_left, sort_right;
         if (gi == 0) begin : g_head
            assign age_left  = ctrl.key;   // new sample enters here on insert
            assign sort_left = TIME_ZERO;
         end else begin : g_body
            assign age_left  = age_q[gi-1];
            assign sort_left = sort_q[gi-1];
         end
         if (gi == SAMPLE_COUNT - 1) begin : g_tail
            assign sort_right = TIME_TOP;  // filler after a delete
         end else begin : g_mid
            assign sort_right = sort_q[gi+1];
         end
         swp_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .age_left   (age_left),
            .sort_left  (sort_left),
            .sort_right (sort_right),
            .age_q      (age_q[gi]),
            .sort_q     (sort_q[gi])
         );
      end
   endgenerate

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.median_time = median_ff;
   assign rsp_chan.p95_time    = p95_ff;
   assign rsp_chan.p99_time    = p99_ff;
   assign rsp_chan.max_time    = max_ff;

   // sorted list keeps its order at the tapped cells
   a_sorted_taps: assert property (@(posedge clock) disable iff (reset)
      sort_q[MEDIAN_POS] <= sort_q[P95_POS] && sort_q[P95_POS] <= sort_q[P99_POS]
      && sort_q[P99_POS] <= sort_q[MAX_POS])
      else $error("sorted chain out of order");

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != ST_IDLE)
      else $error("accepted word did not start work");

   a_delete_then_insert: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DELETE |=> state_ff == ST_INSERT)
      else $error("delete not followed by insert");

   a_result_from_report: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_REPORT))
      else $error("result raised outside report");

endmodule

// ----- test/tb_sliding_window_percentiles.sv -----
`timescale 1ns / 1ps
// Testbench for sliding_window_percentiles: a directed table, then random and
// window-filling streams, scored by a ranking predictor or hand-set reports.
// Depends on swp_pkg, swp_stream_if and the sliding_window_percentiles RTL.
module tb_sliding_window_percentiles;
   import swp_pkg::*;

   // Sorted ranks read by a report, worked out here on their own.
   localparam int RANK_MEDIAN = SAMPLE_COUNT * 50 / 100;
   localparam int RANK_P95    = SAMPLE_COUNT * 95 / 100;
   localparam int RANK_P99    = SAMPLE_COUNT * 99 / 100;
   localparam int RANK_PEAK   = SAMPLE_COUNT - 1;

   // A correct run never goes this long without a word moving: the longest
   // quiet stretch is the receiver hold-off plus one stall burst.
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 16;
   localparam int REPORT_PERCENT  = 20;

   typedef struct packed {
      time_type median_time;
      time_type p95_time;
      time_type p99_time;
      time_type max_time;
   } report_word_type;

   typedef struct {
      logic            kind;
      time_type        sample_time;
      bit              typed;      // want holds a hand-written report
      report_word_type want;
   } plan_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   swp_req_if req_chan ();
   swp_rsp_if rsp_chan ();

   sliding_window_percentiles dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state: our own copy of the window and its write slot.
   time_type        window_ring [SAMPLE_COUNT];
   int unsigned     window_slot;
   report_word_type report_queue [$];   // reports owed by the block, oldest first
   plan_step_type   directed_plan [$];

   int unsigned mismatch_count;
   int unsigned idle_cycles;
   int unsigned req_idle_odds;           // 1-in-N chance of a gap; 0 = never
   int unsigned rsp_idle_odds;
   bit          hold_request;            // asks the receiver for a long hold-off

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      reset = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.kind        = KIND_SAMPLE;
      req_chan.sample_time = TIME_ZERO;
      rsp_chan.ready       = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // Insertion sort on a copy of the window, then pick the ranks.
   function automatic report_word_type rank_window();
      time_type        ordered [SAMPLE_COUNT];
      time_type        key;
      int              j;
      report_word_type ranked;
      ordered = window_ring;
      for (int i = 1; i < SAMPLE_COUNT; i++) begin
         key = ordered[i];
         j   = i;
         while (j > 0 && ordered[j-1] > key) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = key;
      end
      ranked.median_time = ordered[RANK_MEDIAN];
      ranked.p95_time    = ordered[RANK_P95];
      ranked.p99_time    = ordered[RANK_P99];
      ranked.max_time    = ordered[RANK_PEAK];
      return ranked;
   endfunction

   // Applies one accepted word to the window; a report owes one result.
   function automatic void apply_word(input logic kind, input time_type t,
                                      input bit typed, input report_word_type want);
      if (kind == KIND_SAMPLE) begin
         window_ring[window_slot] = t;
         window_slot = (window_slot == SAMPLE_COUNT - 1) ? 0 : window_slot + 1;
      end else if (typed) begin
         report_queue.push_back(want);
      end else begin
         report_queue.push_back(rank_window());
      end
   endfunction

   // ---------------------------------------------------------------- sender

   task automatic pause_sender(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_chan.valid       <= 1'b0;
         req_chan.kind        <= 1'($urandom);   // noise while idle
         req_chan.sample_time <= time_type'($urandom);
      end
   endtask

   // Offers one word from a falling edge and holds it until it is taken.
   task automatic send_word(input logic kind, input time_type t,
                            input bit typed, input report_word_type want);
      @(negedge clock);
      req_chan.valid       <= 1'b1;
      req_chan.kind        <= kind;
      req_chan.sample_time <= t;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      apply_word(kind, t, typed, want);
      if (req_idle_odds != 0 && $urandom_range(1, req_idle_odds) == 1)
         pause_sender($urandom_range(1, 16));
   endtask

   // Spread of frame times: full range, heavy ties near zero, typical frames,
   // and a cluster at and just below saturation.
   function automatic time_type pick_time();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 35)      return time_type'($urandom);
      else if (roll < 55) return time_type'($urandom_range(0, 15));
      else if (roll < 70) return time_type'($urandom_range(16'h0800, 16'h2200));
      else if (roll < 82) return time_type'(TIME_TOP - $urandom_range(0, 15));
      else if (roll < 91) return TIME_TOP;
      else                return TIME_ZERO;
   endfunction

   task automatic send_mixed(input int unsigned report_percent);
      if ($urandom_range(0, 99) < report_percent)
         send_word(KIND_REPORT, time_type'($urandom), 1'b0, '0);
      else
         send_word(KIND_SAMPLE, pick_time(), 1'b0, '0);
   endtask

   // Overwrites the whole window, then asks for a report.
   task automatic refill_window(input bit saturated);
      for (int i = 0; i < SAMPLE_COUNT; i++)
         send_word(KIND_SAMPLE, saturated ? TIME_TOP : pick_time(), 1'b0, '0);
      send_word(KIND_REPORT, time_type'($urandom), 1'b0, '0);
   endtask

   function automatic void add_step(input logic kind, input time_type t, input bit typed,
                                    input time_type med, input time_type p95,
                                    input time_type p99, input time_type peak);
      plan_step_type step;
      step.kind        = kind;
      step.sample_time = t;
      step.typed       = typed;
      step.want        = {med, p95, p99, peak};
      directed_plan.push_back(step);
   endfunction

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      plan_step_type step;
      foreach (window_ring[i]) window_ring[i] = TIME_ZERO;
      window_slot    = 0;
      mismatch_count = 0;
      hold_request   = 1'b0;
      req_idle_odds  = 4;
      rsp_idle_odds  = 4;

      // Fresh window: all slots count as zero, report field bits ignored.
      add_step(KIND_REPORT, 16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      add_step(KIND_REPORT, 16'hFFFF, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      // One saturated sample only reaches the max rank.
      add_step(KIND_SAMPLE, 16'hFFFF, 1'b0, '0, '0, '0, '0);
      add_step(KIND_REPORT, 16'h5A5A, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      // A second nonzero sample lands on the p99 rank.
      add_step(KIND_SAMPLE, 16'h0001, 1'b0, '0, '0, '0, '0);
      add_step(KIND_REPORT, 16'hAAAA, 1'b1, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF);
      add_step(KIND_SAMPLE, 16'h0000, 1'b0, '0, '0, '0, '0);
      add_step(KIND_SAMPLE, 16'h8000, 1'b0, '0, '0, '0, '0);
      add_step(KIND_SAMPLE, 16'h7FFF, 1'b0, '0, '0, '0, '0);
      add_step(KIND_REPORT, 16'h0000, 1'b0, '0, '0, '0, '0);
      add_step(KIND_SAMPLE, 16'h00FF, 1'b0, '0, '0, '0, '0);
      add_step(KIND_SAMPLE, 16'hFF00, 1'b0, '0, '0, '0, '0);
      add_step(KIND_SAMPLE, 16'h5555, 1'b0, '0, '0, '0, '0);
      add_step(KIND_SAMPLE, 16'hAAAA, 1'b0, '0, '0, '0, '0);
      // Equal samples: ties must not disturb any rank.
      add_step(KIND_SAMPLE, 16'h1234, 1'b0, '0, '0, '0, '0);
      add_step(KIND_SAMPLE, 16'h1234, 1'b0, '0, '0, '0, '0);
      add_step(KIND_REPORT, 16'h0F0F, 1'b0, '0, '0, '0, '0);
      add_step(KIND_SAMPLE, 16'hFFFF, 1'b0, '0, '0, '0, '0);
      add_step(KIND_REPORT, 16'hF0F0, 1'b0, '0, '0, '0, '0);

      while (reset) @(posedge clock);

      foreach (directed_plan[i]) begin
         step = directed_plan[i];
         send_word(step.kind, step.sample_time, step.typed, step.want);
      end

      // Mixed traffic; pacing changes per segment, one segment runs flat out.
      for (int seg = 0; seg < 5; seg++) begin
         case (seg)
            0: begin req_idle_odds = 3; rsp_idle_odds = 3; end
            1: begin req_idle_odds = 0; rsp_idle_odds = 0; end
            2: begin req_idle_odds = 8; rsp_idle_odds = 2; end
            3: begin req_idle_odds = 2; rsp_idle_odds = 8; end
            default: begin req_idle_odds = 5; rsp_idle_odds = 0; end
         endcase
         repeat (50) send_mixed(REPORT_PERCENT);
      end

      // Backpressure: the receiver stops for a long stretch while reports keep
      // coming, so the output register fills and the input stalls.
      req_idle_odds = 0;
      rsp_idle_odds = 0;
      hold_request  = 1'b1;
      for (int i = 0; i < 40; i++) begin
         if (i % 4 == 0)
            send_word(KIND_REPORT, time_type'($urandom), 1'b0, '0);
         else
            send_word(KIND_SAMPLE, pick_time(), 1'b0, '0);
      end

      // Whole-window fills: one fully saturated, one with random content.
      req_idle_odds = 6;
      rsp_idle_odds = 6;
      refill_window(1'b1);
      refill_window(1'b0);

      // Last stretch with no idling on either side.
      req_idle_odds = 0;
      rsp_idle_odds = 0;
      repeat (200) send_mixed(REPORT_PERCENT);

      @(negedge clock);
      req_chan.valid <= 1'b0;

      while (report_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   // ready changes on falling edges: random stall bursts, plus one long
   // hold-off counted here when the stimulus asks for it.
   initial begin : rsp_pacing
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left  = 0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_idle_odds != 0 && $urandom_range(1, rsp_idle_odds) == 1) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input report_word_type got,
                                  input report_word_type want);
      mismatch_count++;
      $display("%0t %s: got %h/%h/%h/%h want %h/%h/%h/%h (med/p95/p99/max)", $time, what,
               got.median_time, got.p95_time, got.p99_time, got.max_time,
               want.median_time, want.p95_time, want.p99_time, want.max_time);
   endtask

   always @(posedge clock) begin : rsp_check
      report_word_type got;
      report_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.median_time = rsp_chan.median_time;
         got.p95_time    = rsp_chan.p95_time;
         got.p99_time    = rsp_chan.p99_time;
         got.max_time    = rsp_chan.max_time;
         if (report_queue.size() == 0) begin
            report_mismatch("report word with none owed", got, '0);
         end else begin
            want = report_queue.pop_front();
            if (got.median_time !== want.median_time || got.p95_time !== want.p95_time ||
                got.p99_time !== want.p99_time || got.max_time !== want.max_time)
               report_mismatch("report word differs", got, want);
         end
      end
   end

   // Watchdog: counts cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
